// ===== rtl/bfa_pkg.sv =====
// ============================================================================
// bfa_pkg
// Shared constants, types and codes for the bitmap frame allocator.
// ============================================================================
`default_nettype none

package bfa_pkg;

    localparam int MAX_BLOCKS  = 32768;
    localparam int BLOCK_BYTES = 4096;
    localparam int WORD_BITS   = 32;

    localparam int MAP_WORDS   = MAX_BLOCKS / WORD_BITS;
    localparam int WORD_ADDR_W = $clog2(MAP_WORDS);
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int POP_W       = BIT_W + 1;
    localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
    localparam int IDX_W       = $clog2(MAX_BLOCKS);
    localparam int ADDR_W      = 32;
    localparam int IDX_IN_W    = ADDR_W - BLOCK_SHIFT;
    localparam int CNT_W       = 16;
    localparam int OPC_W       = 3;

    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    // Register index as decoded from paddr[2].
    localparam logic REG_TOTAL_BLOCKS = 1'b0;

    typedef logic [WORD_BITS-1:0] word_t;

    typedef enum logic [OPC_W-1:0] {
        OP_ALLOC         = 3'd0,
        OP_FREE_BLOCK    = 3'd1,
        OP_FREE_RANGE    = 3'd2,
        OP_RESERVE_RANGE = 3'd3,
        OP_MARK_ALL      = 3'd4
    } opcode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_ALLOC_RD,
        ST_ALLOC_CHK,
        ST_RANGE_SETUP,
        ST_RANGE_BOUND,
        ST_WORD_RD,
        ST_WORD_MOD,
        ST_DONE
    } state_t;

    typedef struct packed {
        word_t            range_word;
        logic [POP_W-1:0] changed;
        word_t            alloc_word;
        logic [BIT_W-1:0] free_bit;
        logic             full;
    } wu_res_t;

    typedef struct packed {
        logic [ADDR_W-1:0] block_address;
        logic              status;
        logic [CNT_W-1:0]  free_blocks;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/bitmap_frame_allocator.sv =====
// ============================================================================
// bitmap_frame_allocator
// First-fit bitmap block allocator with a free block counter.
// ============================================================================
// Commands enter on the s_axis channel, one transaction per command, and each
// command produces exactly one result transaction on the m_axis channel.
// The APB port holds total_blocks at byte address 0; writing it restarts the
// bitmap fill.
// An allocate reads and checks the bitmap words in turn from word 0 until one
// holds a free bit or the map ends. Free and reserve commands set up the range
// bounds, then read and rewrite each word touched, and free range adds a pass
// that marks block zero used. Mark all used runs a fill sweep over all 1024
// words, one word per cycle. The steps follow from the single port pair of the
// bitmap memory: one word is read and then rewritten through the shared word
// unit in each step. After reset, and after a write of total_blocks, the block
// sweeps all 1024 words to all ones and accepts no command until it is done.
// A finished result sits in an output register; while the receiver stalls,
// the next command may be accepted and runs until its own result is ready.
// ============================================================================
`default_nettype none

module bitmap_frame_allocator
    import bfa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // APB configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // Command channel
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [63:0]           s_axis_tdata,  // address[31:0], range_bytes[63:32]
    input  logic [OPC_W-1:0]      s_axis_tuser,  // opcode[2:0]
    // Result channel
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [47:0]           m_axis_tdata,  // block_address[31:0], free_blocks[47:32]
    output logic [0:0]            m_axis_tuser   // status[0]
);

    logic [CNT_W-1:0]  total_reg;
    logic [CNT_W-1:0]  eff_blocks;
    logic              cfg_wr;
    logic              res_valid;
    logic              res_ready;
    res_t              res;
    logic              out_valid_reg;
    res_t              out_reg;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_TOTAL_BLOCKS);

    always_comb
    begin
        if (paddr[2] == REG_TOTAL_BLOCKS)
        begin
            prdata = {{(APB_DATA_W-CNT_W){1'b0}}, total_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= CNT_W'(MAX_BLOCKS);
        end
        else if (cfg_wr)
        begin
            total_reg <= pwdata[CNT_W-1:0];
        end
    end

    assign eff_blocks = (total_reg > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : total_reg;

    bfa_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr      (cfg_wr),
        .eff_blocks  (eff_blocks),
        .cmd_valid   (s_axis_tvalid),
        .cmd_ready   (s_axis_tready),
        .cmd_opcode  (s_axis_tuser),
        .cmd_address (s_axis_tdata[31:0]),
        .cmd_range   (s_axis_tdata[63:32]),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.free_blocks, out_reg.block_address};
    assign m_axis_tuser  = out_reg.status;

endmodule

`default_nettype wire

// ===== rtl/bfa_word_unit.sv =====
// ============================================================================
// bfa_word_unit
// Word-wide datapath applied to one bitmap word per step: range masking,
// changed-bit count and lowest-free-bit search.
// ============================================================================
`default_nettype none

module bfa_word_unit
    import bfa_pkg::*;
(
    input  word_t            rd_word,
    input  logic [BIT_W-1:0] lo_bit,
    input  logic [BIT_W-1:0] hi_bit,
    input  logic             set_bits,
    output wu_res_t          res
);

    word_t            mask;
    word_t            new_word;
    word_t            inc_word;
    word_t            low_zero;
    logic [BIT_W-1:0] enc;

    always_comb
    begin
        for (int j = 0; j < WORD_BITS; j++)
        begin
            mask[j] = (BIT_W'(j) >= lo_bit) && (BIT_W'(j) <= hi_bit);
        end
    end

    assign new_word = set_bits ? (rd_word | mask) : (rd_word & ~mask);
    assign inc_word = rd_word + 1'b1;
    assign low_zero = ~rd_word & inc_word;

    always_comb
    begin
        enc = '0;
        for (int j = 0; j < WORD_BITS; j++)
        begin
            if (low_zero[j])
            begin
                enc = enc | BIT_W'(j);
            end
        end
    end

    always_comb
    begin
        res.range_word = new_word;
        res.changed    = POP_W'($countones(rd_word ^ new_word));
        res.alloc_word = rd_word | inc_word;
        res.free_bit   = enc;
        res.full       = &rd_word;
    end

endmodule

`default_nettype wire

// ===== rtl/bfa_core.sv =====
// ============================================================================
// bfa_core
// Command sequencer with the usage bitmap memory and the free block counter.
// ============================================================================
`default_nettype none

module bfa_core
    import bfa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr,
    input  logic [CNT_W-1:0]    eff_blocks,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  logic [OPC_W-1:0]    cmd_opcode,
    input  logic [ADDR_W-1:0]   cmd_address,
    input  logic [ADDR_W-1:0]   cmd_range,
    output logic                res_valid,
    input  logic                res_ready,
    output res_t                res
);

    state_t                   state_reg, state_next;
    logic [WORD_ADDR_W-1:0]   sweep_w_reg, sweep_w_next;
    logic [WORD_ADDR_W:0]     scan_reg, scan_next;
    logic [WORD_ADDR_W-1:0]   cur_w_reg, cur_w_next;
    logic [WORD_ADDR_W-1:0]   last_w_reg, last_w_next;
    logic [BIT_W-1:0]         lo_reg, lo_next;
    logic [BIT_W-1:0]         hi_reg, hi_next;
    logic [IDX_IN_W-1:0]      start_reg, start_next;
    logic [IDX_IN_W-1:0]      len_reg, len_next;
    logic [CNT_W-1:0]         end_c_reg, end_c_next;
    logic                     set_reg, set_next;
    logic                     fix_reg, fix_next;
    logic                     pend_reg, pend_next;
    logic [CNT_W-1:0]         free_count_reg, free_count_next;
    logic [ADDR_W-1:0]        res_addr_reg, res_addr_next;
    logic                     res_status_reg, res_status_next;
    word_t                    rd_word_reg;

    word_t                    mem [MAP_WORDS];
    logic                     mem_we;
    logic [WORD_ADDR_W-1:0]   mem_wa;
    word_t                    mem_wd;
    logic                     mem_re;
    logic [WORD_ADDR_W-1:0]   mem_ra;

    wu_res_t                  wu;
    logic [BIT_W-1:0]         wu_hi;
    logic [WORD_ADDR_W:0]     words;
    logic                     scan_live;
    logic [IDX_IN_W:0]        end_sum;
    logic                     in_range;
    logic [CNT_W-1:0]         last_blk;
    logic                     last_word;
    logic [IDX_W-1:0]         alloc_idx;

    assign wu_hi     = (cur_w_reg == last_w_reg) ? hi_reg : '1;
    assign words     = eff_blocks[CNT_W-1:BIT_W];
    assign scan_live = scan_reg < words;
    assign end_sum   = {1'b0, start_reg} + {1'b0, len_reg};
    assign in_range  = start_reg < {{(IDX_IN_W-CNT_W){1'b0}}, end_c_reg};
    assign last_blk  = end_c_reg - 1'b1;
    assign last_word = cur_w_reg == last_w_reg;
    assign alloc_idx = {scan_reg[WORD_ADDR_W-1:0], wu.free_bit};

    bfa_word_unit u_word_unit (
        .rd_word  (rd_word_reg),
        .lo_bit   (lo_reg),
        .hi_bit   (wu_hi),
        .set_bits (set_reg),
        .res      (wu)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd_opcode) inside
                        OP_ALLOC:
                        begin
                            state_next = (free_count_reg == '0) ? ST_DONE : ST_ALLOC_RD;
                        end
                        OP_FREE_BLOCK, OP_FREE_RANGE, OP_RESERVE_RANGE:
                        begin
                            state_next = ST_RANGE_SETUP;
                        end
                        OP_MARK_ALL:
                        begin
                            state_next = ST_SWEEP;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SWEEP:
            begin
                if (sweep_w_reg == WORD_ADDR_W'(MAP_WORDS - 1))
                begin
                    state_next = pend_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_ALLOC_RD:
            begin
                state_next = scan_live ? ST_ALLOC_CHK : ST_DONE;
            end
            ST_ALLOC_CHK:
            begin
                state_next = wu.full ? ST_ALLOC_RD : ST_DONE;
            end
            ST_RANGE_SETUP:
            begin
                state_next = ST_RANGE_BOUND;
            end
            ST_RANGE_BOUND:
            begin
                if (in_range)
                begin
                    state_next = ST_WORD_RD;
                end
                else
                begin
                    state_next = fix_reg ? ST_RANGE_SETUP : ST_DONE;
                end
            end
            ST_WORD_RD:
            begin
                state_next = ST_WORD_MOD;
            end
            ST_WORD_MOD:
            begin
                if (last_word)
                begin
                    state_next = fix_reg ? ST_RANGE_SETUP : ST_DONE;
                end
                else
                begin
                    state_next = ST_WORD_RD;
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (cfg_wr)
        begin
            state_next = ST_SWEEP;
        end
    end

    always_comb
    begin
        sweep_w_next    = sweep_w_reg;
        scan_next       = scan_reg;
        cur_w_next      = cur_w_reg;
        last_w_next     = last_w_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        start_next      = start_reg;
        len_next        = len_reg;
        end_c_next      = end_c_reg;
        set_next        = set_reg;
        fix_next        = fix_reg;
        pend_next       = pend_reg;
        free_count_next = free_count_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        mem_we          = 1'b0;
        mem_wa          = cur_w_reg;
        mem_wd          = wu.range_word;
        mem_re          = 1'b0;
        mem_ra          = cur_w_reg;
        cmd_ready       = 1'b0;
        res_valid       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    start_next      = cmd_address[ADDR_W-1:BLOCK_SHIFT];
                    len_next        = (cmd_opcode == OP_FREE_BLOCK) ? IDX_IN_W'(1)
                                                                    : cmd_range[ADDR_W-1:BLOCK_SHIFT];
                    set_next        = cmd_opcode == OP_RESERVE_RANGE;
                    fix_next        = cmd_opcode == OP_FREE_RANGE;
                    pend_next       = cmd_opcode == OP_MARK_ALL;
                    scan_next       = '0;
                    res_addr_next   = '0;
                    res_status_next = (cmd_opcode == OP_ALLOC) && (free_count_reg == '0);
                    if (cmd_opcode == OP_MARK_ALL)
                    begin
                        sweep_w_next    = '0;
                        free_count_next = '0;
                    end
                end
            end
            ST_SWEEP:
            begin
                mem_we       = 1'b1;
                mem_wa       = sweep_w_reg;
                mem_wd       = '1;
                sweep_w_next = sweep_w_reg + 1'b1;
            end
            ST_ALLOC_RD:
            begin
                mem_re = scan_live;
                mem_ra = scan_reg[WORD_ADDR_W-1:0];
                if (!scan_live)
                begin
                    res_status_next = 1'b1;
                end
            end
            ST_ALLOC_CHK:
            begin
                mem_wa = scan_reg[WORD_ADDR_W-1:0];
                mem_wd = wu.alloc_word;
                if (wu.full)
                begin
                    scan_next = scan_reg + 1'b1;
                end
                else
                begin
                    mem_we          = 1'b1;
                    free_count_next = free_count_reg - 1'b1;
                    res_addr_next   = {{(ADDR_W-IDX_W){1'b0}}, alloc_idx} << BLOCK_SHIFT;
                end
            end
            ST_RANGE_SETUP:
            begin
                end_c_next = (end_sum > {{(IDX_IN_W+1-CNT_W){1'b0}}, eff_blocks})
                             ? eff_blocks : end_sum[CNT_W-1:0];
            end
            ST_RANGE_BOUND:
            begin
                if (in_range)
                begin
                    cur_w_next  = start_reg[IDX_W-1:BIT_W];
                    last_w_next = last_blk[IDX_W-1:BIT_W];
                    lo_next     = start_reg[BIT_W-1:0];
                    hi_next     = last_blk[BIT_W-1:0];
                end
                else if (fix_reg)
                begin
                    fix_next   = 1'b0;
                    start_next = '0;
                    len_next   = IDX_IN_W'(1);
                    set_next   = 1'b1;
                end
            end
            ST_WORD_RD:
            begin
                mem_re = 1'b1;
            end
            ST_WORD_MOD:
            begin
                mem_we = 1'b1;
                if (set_reg)
                begin
                    free_count_next = free_count_reg - {{(CNT_W-POP_W){1'b0}}, wu.changed};
                end
                else
                begin
                    free_count_next = free_count_reg + {{(CNT_W-POP_W){1'b0}}, wu.changed};
                end
                if (last_word)
                begin
                    if (fix_reg)
                    begin
                        fix_next   = 1'b0;
                        start_next = '0;
                        len_next   = IDX_IN_W'(1);
                        set_next   = 1'b1;
                    end
                end
                else
                begin
                    cur_w_next = cur_w_reg + 1'b1;
                    lo_next    = '0;
                end
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase

        if (cfg_wr)
        begin
            sweep_w_next    = '0;
            free_count_next = '0;
            pend_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            sweep_w_reg    <= '0;
            pend_reg       <= 1'b0;
            fix_reg        <= 1'b0;
            free_count_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_w_reg    <= sweep_w_next;
            pend_reg       <= pend_next;
            fix_reg        <= fix_next;
            free_count_reg <= free_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg       <= scan_next;
        cur_w_reg      <= cur_w_next;
        last_w_reg     <= last_w_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        start_reg      <= start_next;
        len_reg        <= len_next;
        end_c_reg      <= end_c_next;
        set_reg        <= set_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_word_reg <= mem[mem_ra];
        end
    end

    always_comb
    begin
        res.block_address = res_addr_reg;
        res.status        = res_status_reg;
        res.free_blocks   = free_count_reg;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_count_reg <= CNT_W'(MAX_BLOCKS))
        else $error("free block count exceeds the bitmap size");

    a_sweep_zero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SWEEP |-> free_count_reg == '0)
        else $error("free block count is not zero during a fill sweep");

    a_scan_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ALLOC_RD |-> free_count_reg != '0)
        else $error("allocation scan started with no free blocks");

    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg != ST_IDLE && state_reg != ST_DONE))
        else $error("bitmap written while no command is in progress");

    a_fail_addr: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status_reg |-> res_addr_reg == '0)
        else $error("failed allocation returns a nonzero address");

endmodule

`default_nettype wire

// ===== dv/tb_bitmap_frame_allocator.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_bitmap_frame_allocator
// Self-checking testbench for the first-fit bitmap frame allocator.
// ============================================================================
// Commands go in on the s_axis channel and every result transaction on m_axis
// is checked field by field against a behavioral model of the bitmap and its
// free block counter. Directed tests cover the reset state, the special cases
// of allocation and range handling, and a map that ends in a partial word.
// A long receiver hold fills the block, and random phases run over a range of
// total_blocks settings, including zero and the largest value. Random idle
// gaps are applied on both channels.
// ============================================================================

module tb_bitmap_frame_allocator;
    import bfa_pkg::*;

    localparam logic [OPC_W-1:0]      OP_UNDEF_5        = 3'd5;
    localparam logic [OPC_W-1:0]      OP_UNDEF_6        = 3'd6;
    localparam logic [OPC_W-1:0]      OP_UNDEF_7        = 3'd7;
    localparam logic [APB_ADDR_W-1:0] TOTAL_BLOCKS_ADDR = {REG_TOTAL_BLOCKS, 2'b00};
    localparam int                    WATCHDOG_LIMIT    = 20000;
    localparam int                    DRAIN_CYCLES      = 2200;
    localparam int                    HOLD_OFF_CYCLES   = 300;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [63:0]           s_axis_tdata;  // address[31:0], range_bytes[63:32]
    logic [OPC_W-1:0]      s_axis_tuser;  // opcode[2:0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [47:0]           m_axis_tdata;  // block_address[31:0], free_blocks[47:32]
    logic [0:0]            m_axis_tuser;  // status[0]

    bit          block_used [MAX_BLOCKS];
    int unsigned free_total;
    int unsigned total_blocks_reg;
    res_t        expected_results [$];

    int unsigned mismatches;
    int unsigned cmds_sent;
    int unsigned results_checked;
    int unsigned allocs_granted;
    int unsigned allocs_refused;
    int unsigned map_sizes_run;
    int unsigned hold_cycles;
    bit          no_idle;

    bitmap_frame_allocator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int unsigned eff_count();
        return (total_blocks_reg < MAX_BLOCKS) ? total_blocks_reg : MAX_BLOCKS;
    endfunction

    function automatic void fill_used();
        foreach (block_used[k])
            block_used[k] = 1'b1;
        free_total = 0;
    endfunction

    function automatic void put_block(input longint unsigned idx, input bit used);
        if (idx >= eff_count() || block_used[idx] == used)
            return;
        block_used[idx] = used;
        if (used)
            free_total--;
        else
            free_total++;
    endfunction

    function automatic void mark_range(input logic [31:0] addr, input logic [31:0] nbytes,
                                       input bit used);
        longint unsigned first;
        longint unsigned stop;
        longint unsigned i;
        first = addr / BLOCK_BYTES;
        stop  = first + nbytes / BLOCK_BYTES;
        if (stop > eff_count())
            stop = eff_count();
        for (i = first; i < stop; i++)
            put_block(i, used);
    endfunction

    function automatic res_t apply_command(input logic [OPC_W-1:0] op,
                                           input logic [31:0] addr,
                                           input logic [31:0] nbytes);
        res_t            r;
        longint unsigned scan_end;
        longint unsigned i;
        r.block_address = '0;
        r.status        = 1'b0;
        case (op)
            OP_ALLOC:
            begin
                r.status = 1'b1;
                if (free_total != 0)
                begin
                    scan_end = (eff_count() / WORD_BITS) * WORD_BITS;
                    for (i = 0; i < scan_end; i++)
                    begin
                        if (!block_used[i])
                        begin
                            put_block(i, 1'b1);
                            r.block_address = 32'(i * BLOCK_BYTES);
                            r.status        = 1'b0;
                            break;
                        end
                    end
                end
                if (r.status)
                    allocs_refused++;
                else
                    allocs_granted++;
            end
            OP_FREE_BLOCK:    put_block(addr / BLOCK_BYTES, 1'b0);
            OP_FREE_RANGE:
            begin
                mark_range(addr, nbytes, 1'b0);
                put_block(0, 1'b1);
            end
            OP_RESERVE_RANGE: mark_range(addr, nbytes, 1'b1);
            OP_MARK_ALL:      fill_used();
            default:          ;
        endcase
        r.free_blocks = free_total[CNT_W-1:0];
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [OPC_W-1:0] pick_op();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40) return OP_ALLOC;
        if (r < 62) return OP_FREE_BLOCK;
        if (r < 76) return OP_FREE_RANGE;
        if (r < 90) return OP_RESERVE_RANGE;
        if (r < 94) return OP_MARK_ALL;
        if (r < 96) return OP_UNDEF_5;
        if (r < 98) return OP_UNDEF_6;
        return OP_UNDEF_7;
    endfunction

    function automatic logic [31:0] rand_addr(input int unsigned eff);
        logic [31:0] idx;
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        idx = $urandom_range(0, eff + eff / 8 + 1);
        return (idx * BLOCK_BYTES) | $urandom_range(0, BLOCK_BYTES - 1);
    endfunction

    function automatic logic [31:0] rand_bytes(input int unsigned eff);
        int unsigned r;
        logic [31:0] nblk;
        r = $urandom_range(0, 9);
        if (r == 0)
            return $urandom;
        nblk = (r < 3) ? $urandom_range(0, eff) : $urandom_range(0, 8);
        return (nblk * BLOCK_BYTES) | $urandom_range(0, BLOCK_BYTES - 1);
    endfunction

    task automatic send_cmd(input logic [OPC_W-1:0] op, input logic [31:0] addr,
                            input logic [31:0] nbytes);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {nbytes, addr};
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        expected_results.push_back(apply_command(op, addr, nbytes));
        cmds_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_total_blocks(input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TOTAL_BLOCKS_ADDR;
        pwdata  <= {16'h0000, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        total_blocks_reg = {16'h0000, value};
        fill_used();
    endtask

    task automatic test_directed();
        send_cmd(OP_ALLOC, 32'h0, 32'h0);
        send_cmd(OP_FREE_RANGE, 32'h0, 32'h0001_0000);
        send_cmd(OP_ALLOC, 32'h0, 32'h0);
        send_cmd(OP_FREE_BLOCK, 32'h0, 32'h0);
        send_cmd(OP_ALLOC, 32'h0, 32'h0);
        send_cmd(OP_RESERVE_RANGE, 32'h0000_2000, 32'h0000_3000);
        send_cmd(OP_ALLOC, 32'h0, 32'h0);
        send_cmd(OP_FREE_BLOCK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(OP_FREE_RANGE, 32'hFFFF_F000, 32'hFFFF_FFFF);
        send_cmd(OP_FREE_RANGE, 32'h0000_3000, 32'h0000_1FFF);
        send_cmd(OP_RESERVE_RANGE, 32'h0, 32'hFFFF_FFFF);
        send_cmd(OP_ALLOC, 32'h0, 32'h0);
        send_cmd(OP_UNDEF_5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(OP_UNDEF_6, 32'h0, 32'h0);
        send_cmd(OP_UNDEF_7, 32'hA5A5_5A5A, 32'h5A5A_A5A5);
        send_cmd(OP_FREE_RANGE, 32'h0, 32'hFFFF_FFFF);
        send_cmd(OP_ALLOC, 32'h0, 32'h0);
        send_cmd(OP_MARK_ALL, 32'h0, 32'h0);
        send_cmd(OP_ALLOC, 32'h0, 32'h0);
        send_cmd(OP_FREE_BLOCK, 32'h0000_0FFF, 32'h0);
        send_cmd(OP_ALLOC, 32'h0, 32'h0);
        wait_drained();
    endtask

    task automatic test_partial_word();
        write_total_blocks(16'd40);
        send_cmd(OP_FREE_RANGE, 32'h0, 40 * BLOCK_BYTES);
        send_cmd(OP_RESERVE_RANGE, BLOCK_BYTES, 31 * BLOCK_BYTES);
        send_cmd(OP_ALLOC, 32'h0, 32'h0);
        send_cmd(OP_FREE_BLOCK, 40 * BLOCK_BYTES, 32'h0);
        send_cmd(OP_ALLOC, 32'h0, 32'h0);
        send_cmd(OP_FREE_BLOCK, 5 * BLOCK_BYTES, 32'h0);
        send_cmd(OP_ALLOC, 32'h0, 32'h0);
        wait_drained();
    endtask

    task automatic test_backpressure();
        int unsigned k;
        send_cmd(OP_FREE_RANGE, 32'h0, 32'hFFFF_F000);
        no_idle     = 1'b1;
        hold_cycles = HOLD_OFF_CYCLES;
        for (k = 0; k < 10; k++)
            send_cmd(pick_op(), rand_addr(eff_count()), rand_bytes(eff_count()));
        no_idle = 1'b0;
        wait_drained();
    endtask

    task automatic test_random();
        int unsigned phase_size  [11] = '{256, 33, 1000, 1, 0, 65535, 100, 31, 32768, 64, 512};
        int unsigned phase_items [11] = '{150, 100, 150, 60, 40, 60, 120, 80, 60, 150, 130};
        int unsigned p;
        int unsigned k;
        int unsigned eff;
        for (p = 0; p < 11; p++)
        begin
            write_total_blocks(phase_size[p][15:0]);
            map_sizes_run++;
            eff = eff_count();
            send_cmd(OP_FREE_RANGE, 32'h0, 32'hFFFF_F000);
            for (k = 0; k < phase_items[p]; k++)
            begin
                if (k % 50 == 0)
                    no_idle = ($urandom_range(0, 4) == 0);
                if (k % 40 == 39 && $urandom_range(0, 3) == 0)
                    wait_drained();
                send_cmd(pick_op(), rand_addr(eff), rand_bytes(eff));
            end
            no_idle = 1'b0;
            wait_drained();
        end
    endtask

    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            int unsigned rx_wait;
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_cycles--;
            end
            else if (rx_wait > 0)
            begin
                m_axis_tready <= 1'b0;
                rx_wait--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                rx_wait = pick_gap();
            end
        end
    end

    initial
    begin
        res_t want;
        res_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                got.block_address = m_axis_tdata[31:0];
                got.free_blocks   = m_axis_tdata[47:32];
                got.status        = m_axis_tuser[0];
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result transaction: block_address %h status %0d free_blocks %0d",
                             $time, got.block_address, got.status, got.free_blocks);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (got.block_address !== want.block_address)
                        $display("%0t: block_address mismatch: expected %h, actual %h",
                                 $time, want.block_address, got.block_address);
                    if (got.status !== want.status)
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, got.status);
                    if (got.free_blocks !== want.free_blocks)
                        $display("%0t: free_blocks mismatch: expected %0d, actual %0d",
                                 $time, want.free_blocks, got.free_blocks);
                    if (got !== want)
                        mismatches++;
                end
            end
        end
    end

    initial
    begin
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: watchdog expired, no transaction for %0d cycles, %0d results pending",
                 $time, WATCHDOG_LIMIT, expected_results.size());
        $display("bitmap_frame_allocator test failed");
        $finish;
    end

    initial
    begin
        rst_n         <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        total_blocks_reg = MAX_BLOCKS;
        fill_used();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_partial_word();
        test_backpressure();
        test_random();

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Ran %0d commands over %0d map sizes and checked %0d results.",
                 cmds_sent, map_sizes_run + 2, results_checked);
        $display("Allocations granted %0d, refused %0d; long output hold and drains included.",
                 allocs_granted, allocs_refused);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("bitmap_frame_allocator test passed");
        else
            $display("bitmap_frame_allocator test failed");
        $finish;
    end

endmodule
